// ===== design/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants of the I2C master bit sequencer
// Holds the request and result payload types, the command codes and the
// sequencer state record that passes between the datapath and the registers.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Command codes carried in the op field of a request
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_WAIT  = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd200;
  localparam logic [3:0] LAST_BIT          = 4'd7;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_A    = 5'd1,
    PH_ST_B    = 5'd2,
    PH_SP_A    = 5'd3,
    PH_SP_B    = 5'd4,
    PH_WR      = 5'd5,
    PH_WA_SET  = 5'd6,
    PH_WA_POLL = 5'd7,
    PH_WA_LOW  = 5'd8,
    PH_WA_SP_A = 5'd9,
    PH_WA_SP_B = 5'd10,
    PH_RD      = 5'd11,
    PH_RD_AK_A = 5'd12,
    PH_RD_AK_B = 5'd13
  } phase_e;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       ready_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } res_t;

  typedef struct packed {
    phase_e     phase;
    logic [1:0] sub_slot;
    logic [3:0] bit_index;
    logic [7:0] shift_reg;
    logic [7:0] wait_count;
    logic       scl_level;
    logic       sda_level;
    logic       ack_choice;
    logic [7:0] read_result;
    logic       fail_flag;
  } seq_state_t;

endpackage

// ===== design/i2cm_step.sv =====
// ----------------------------------------------------------------------------
// i2cm_step: one timing slot of the line sequencer
// Combinational next-state and line-drive logic for a single slot.
// ----------------------------------------------------------------------------
module i2cm_step
  import i2cm_pkg::*;
(
  input  seq_state_t state_i,
  input  req_t       req_i,
  input  logic [7:0] ack_timeout_i,
  output seq_state_t state_o,
  output res_t       res_o
);

  seq_state_t st;
  logic       scl_o;
  logic       sda_o;
  logic       done;

  always_comb begin
    st    = state_i;
    done  = 1'b0;

    // Latch a new command only when idle; commands while busy are dropped
    if (st.phase == PH_IDLE) begin
      st.sub_slot  = 2'd0;
      st.bit_index = 4'd0;
      case (req_i.op)
        OP_START: st.phase = PH_ST_A;
        OP_STOP:  st.phase = PH_SP_A;
        OP_WRITE: begin
          st.phase     = PH_WR;
          st.shift_reg = req_i.tx_byte;
        end
        OP_WAIT: begin
          st.phase      = PH_WA_SET;
          st.wait_count = 8'd0;
        end
        OP_READ: begin
          st.phase      = PH_RD;
          st.shift_reg  = 8'd0;
          st.ack_choice = req_i.send_ack;
        end
        default: ;
      endcase
    end

    scl_o = st.scl_level;
    sda_o = st.sda_level;

    unique case (st.phase)
      PH_IDLE: ;
      PH_ST_A: begin
        scl_o    = 1'b1;
        sda_o    = 1'b1;
        st.phase = PH_ST_B;
      end
      PH_ST_B: begin
        scl_o        = 1'b1;
        sda_o        = 1'b0;
        done         = 1'b1;
        st.phase     = PH_IDLE;
        st.scl_level = 1'b0;
        st.sda_level = 1'b0;
      end
      PH_SP_A, PH_WA_SP_A: begin
        scl_o    = 1'b0;
        sda_o    = 1'b0;
        st.phase = (st.phase == PH_SP_A) ? PH_SP_B : PH_WA_SP_B;
      end
      PH_SP_B, PH_WA_SP_B: begin
        scl_o = 1'b1;
        sda_o = 1'b1;
        done  = 1'b1;
        if (st.phase == PH_WA_SP_B) begin
          st.fail_flag = 1'b1;
        end
        st.phase     = PH_IDLE;
        st.scl_level = 1'b1;
        st.sda_level = 1'b1;
      end
      PH_WR: begin
        sda_o = st.shift_reg[7];
        scl_o = (st.sub_slot == 2'd1);
        if (st.sub_slot >= 2'd2) begin
          st.sub_slot  = 2'd0;
          st.shift_reg = {st.shift_reg[6:0], 1'b0};
          if (st.bit_index >= LAST_BIT) begin
            done         = 1'b1;
            st.phase     = PH_IDLE;
            st.bit_index = 4'd0;
          end else begin
            st.bit_index = st.bit_index + 4'd1;
          end
        end else begin
          st.sub_slot = st.sub_slot + 2'd1;
        end
        st.scl_level = 1'b0;
        st.sda_level = sda_o;
      end
      PH_WA_SET: begin
        scl_o        = 1'b1;
        sda_o        = 1'b1;
        st.phase     = PH_WA_POLL;
        st.scl_level = 1'b1;
        st.sda_level = 1'b1;
      end
      PH_WA_POLL: begin
        scl_o = 1'b1;
        sda_o = 1'b1;
        priority if (!req_i.sda_in) begin
          st.phase = PH_WA_LOW;
        end else if (st.wait_count >= ack_timeout_i) begin
          st.phase = PH_WA_SP_A;
        end else begin
          st.wait_count = st.wait_count + 8'd1;
        end
      end
      PH_WA_LOW: begin
        scl_o        = 1'b0;
        sda_o        = 1'b1;
        done         = 1'b1;
        st.fail_flag = 1'b0;
        st.phase     = PH_IDLE;
        st.scl_level = 1'b0;
        st.sda_level = 1'b1;
      end
      PH_RD: begin
        sda_o = 1'b1;
        if (st.sub_slot == 2'd0) begin
          scl_o       = 1'b0;
          st.sub_slot = 2'd1;
        end else begin
          scl_o        = 1'b1;
          st.sub_slot  = 2'd0;
          st.shift_reg = {st.shift_reg[6:0], req_i.sda_in};
          if (st.bit_index >= LAST_BIT) begin
            st.bit_index = 4'd0;
            st.phase     = PH_RD_AK_A;
          end else begin
            st.bit_index = st.bit_index + 4'd1;
          end
        end
        st.scl_level = scl_o;
        st.sda_level = 1'b1;
      end
      PH_RD_AK_A: begin
        scl_o        = 1'b0;
        sda_o        = ~st.ack_choice;
        st.phase     = PH_RD_AK_B;
        st.scl_level = 1'b0;
        st.sda_level = sda_o;
      end
      PH_RD_AK_B: begin
        scl_o          = 1'b1;
        sda_o          = ~st.ack_choice;
        done           = 1'b1;
        st.read_result = st.shift_reg;
        st.phase       = PH_IDLE;
        st.scl_level   = 1'b0;
        st.sda_level   = sda_o;
      end
      default: st.phase = PH_IDLE;
    endcase
  end

  assign state_o = st;

  assign res_o.scl_out    = scl_o;
  assign res_o.sda_out    = sda_o;
  assign res_o.ready_res  = (st.phase == PH_IDLE);
  assign res_o.done_res   = done;
  assign res_o.rx_byte    = st.read_result;
  assign res_o.ack_failed = st.fail_flag;

endmodule

// ===== design/i2c_master_bit_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_top: I2C master line sequencer, one slot per request
// Each input request is one timing slot of a bit-banged I2C master; each
// yields one result with the SCL/SDA drive levels and status.
//
// Usage:
//   - Input channel (in_valid_i / in_stall_o / in_req_i): one request per
//     slot, carrying the command (used only while idle) and sampled SDA.
//   - Output channel (out_valid_o / out_stall_i / out_res_o): one result per
//     request, in order.
//   - Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): writes the
//     ack timeout in slots; always ready. Write it only while idle.
//   - Result timing: a result appears in the cycle after its request is taken.
//   - Throughput: one request per cycle; the output register is the only
//     storage stage, and a new request is taken whenever that register is
//     empty or being drained in the same cycle.
//   - Stall: while out_stall_i holds a waiting result, in_stall_o is raised
//     and the sequencer state does not advance.
//   - Reset: idle, both lines released high, timeout back to 200 slots, no
//     result pending.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_top
  import i2cm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  req_t       in_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output res_t       out_res_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  seq_state_t state_q;
  seq_state_t state_d;
  res_t       res_d;
  res_t       res_q;
  logic       out_valid_q;
  logic [7:0] ack_timeout_q;
  logic       accept;

  // Hold the input back only while a finished result is stuck downstream
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  i2cm_step u_step (
    .state_i       (state_q),
    .req_i         (in_req_i),
    .ack_timeout_i (ack_timeout_q),
    .state_o       (state_d),
    .res_o         (res_d)
  );

  // Control state: sequencer record, result valid and the timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= '{phase: PH_IDLE, sub_slot: 2'd0, bit_index: 4'd0,
                         shift_reg: 8'd0, wait_count: 8'd0, scl_level: 1'b1,
                         sda_level: 1'b1, ack_choice: 1'b0, read_result: 8'd0,
                         fail_flag: 1'b0};
      out_valid_q   <= 1'b0;
      ack_timeout_q <= ACK_TIMEOUT_RESET;
    end else begin
      if (accept) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        ack_timeout_q <= cfg_data_i;
      end
    end
  end

  // Result payload: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

// ===== tb/sv/i2c_master_bit_sequencer_top_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_top_tb: slot-level check of the I2C line sequencer
// Feeds timing-slot requests with commands and sampled SDA levels, predicts
// every slot's SCL/SDA drive and status, and compares each result in order.
// Directed tests cover idle slots, writes, reads, ack waits and the timeout
// register; random phases follow, all but the last with stalls and gaps on both channels.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cm_pkg::*;

  // Op codes with no command behind them; the sequencer treats them as none.
  localparam logic [2:0] OP_RSVD_A = 3'd6;
  localparam logic [2:0] OP_RSVD_B = 3'd7;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_stall;
  req_t       in_req;
  logic       out_valid;
  logic       out_stall;
  res_t       out_res;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  i2c_master_bit_sequencer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_res_o   (out_res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // Free-running clock, 8 ns period.
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Predicted line sequencer state, kept in step with accepted requests.
  phase_e     line_phase;
  logic [1:0] line_sub;
  logic [3:0] line_bit;
  logic [7:0] line_shift;
  logic [7:0] line_polls;
  logic [7:0] line_timeout;
  logic [7:0] line_rx;
  logic       line_scl;
  logic       line_sda;
  logic       line_ack;
  logic       line_fail;

  res_t expected_slots[$];
  int   errors;
  int   slots_sent;
  bit   calm;

  // Advance the predicted sequencer by one slot and return its result.
  function automatic res_t advance_slot(input req_t slot);
    res_t o;
    logic done;
    o    = '0;
    done = 1'b0;
    // A command only starts from idle; anything arriving while busy is dropped.
    if (line_phase == PH_IDLE) begin
      line_sub = '0;
      line_bit = '0;
      case (slot.op)
        OP_START: line_phase = PH_ST_A;
        OP_STOP:  line_phase = PH_SP_A;
        OP_WRITE: begin
          line_phase = PH_WR;
          line_shift = slot.tx_byte;
        end
        OP_WAIT: begin
          line_phase = PH_WA_SET;
          line_polls = '0;
        end
        OP_READ: begin
          line_phase = PH_RD;
          line_shift = '0;
          line_ack   = slot.send_ack;
        end
        default: ;
      endcase
    end
    o.scl_out = line_scl;
    o.sda_out = line_sda;
    case (line_phase)
      PH_ST_A: begin
        o.scl_out  = 1'b1;
        o.sda_out  = 1'b1;
        line_phase = PH_ST_B;
      end
      PH_ST_B: begin
        o.scl_out  = 1'b1;
        o.sda_out  = 1'b0;
        done       = 1'b1;
        line_phase = PH_IDLE;
        line_scl   = 1'b0;
        line_sda   = 1'b0;
      end
      PH_SP_A, PH_WA_SP_A: begin
        o.scl_out  = 1'b0;
        o.sda_out  = 1'b0;
        line_phase = (line_phase == PH_SP_A) ? PH_SP_B : PH_WA_SP_B;
      end
      PH_SP_B, PH_WA_SP_B: begin
        o.scl_out = 1'b1;
        o.sda_out = 1'b1;
        done      = 1'b1;
        // A stop that closes a timed-out ack wait raises the failure flag.
        if (line_phase == PH_WA_SP_B) line_fail = 1'b1;
        line_phase = PH_IDLE;
        line_scl   = 1'b1;
        line_sda   = 1'b1;
      end
      PH_WR: begin
        o.sda_out = line_shift[7];
        o.scl_out = (line_sub == 2'd1);
        if (line_sub >= 2'd2) begin
          line_sub   = '0;
          line_shift = {line_shift[6:0], 1'b0};
          if (line_bit >= LAST_BIT) begin
            done       = 1'b1;
            line_phase = PH_IDLE;
            line_bit   = '0;
          end else begin
            line_bit = line_bit + 4'd1;
          end
        end else begin
          line_sub = line_sub + 2'd1;
        end
        line_scl = 1'b0;
        line_sda = o.sda_out;
      end
      PH_WA_SET: begin
        o.scl_out  = 1'b1;
        o.sda_out  = 1'b1;
        line_phase = PH_WA_POLL;
        line_scl   = 1'b1;
        line_sda   = 1'b1;
      end
      PH_WA_POLL: begin
        o.scl_out = 1'b1;
        o.sda_out = 1'b1;
        if (!slot.sda_in) begin
          line_phase = PH_WA_LOW;
        end else if (line_polls >= line_timeout) begin
          line_phase = PH_WA_SP_A;
        end else begin
          line_polls = line_polls + 8'd1;
        end
      end
      PH_WA_LOW: begin
        o.scl_out  = 1'b0;
        o.sda_out  = 1'b1;
        done       = 1'b1;
        line_fail  = 1'b0;
        line_phase = PH_IDLE;
        line_scl   = 1'b0;
        line_sda   = 1'b1;
      end
      PH_RD: begin
        o.sda_out = 1'b1;
        if (line_sub == 2'd0) begin
          o.scl_out = 1'b0;
          line_sub  = 2'd1;
        end else begin
          o.scl_out  = 1'b1;
          line_sub   = 2'd0;
          line_shift = {line_shift[6:0], slot.sda_in};
          if (line_bit >= LAST_BIT) begin
            line_bit   = '0;
            line_phase = PH_RD_AK_A;
          end else begin
            line_bit = line_bit + 4'd1;
          end
        end
        line_scl = o.scl_out;
        line_sda = 1'b1;
      end
      PH_RD_AK_A: begin
        o.scl_out  = 1'b0;
        o.sda_out  = ~line_ack;
        line_phase = PH_RD_AK_B;
        line_scl   = 1'b0;
        line_sda   = o.sda_out;
      end
      PH_RD_AK_B: begin
        o.scl_out  = 1'b1;
        o.sda_out  = ~line_ack;
        done       = 1'b1;
        line_rx    = line_shift;
        line_phase = PH_IDLE;
        line_scl   = 1'b0;
        line_sda   = o.sda_out;
      end
      default: line_phase = PH_IDLE;
    endcase
    o.ready_res  = (line_phase == PH_IDLE);
    o.done_res   = done;
    o.rx_byte    = line_rx;
    o.ack_failed = line_fail;
    return o;
  endfunction

  // Drive one request at the falling edge, hold it until taken, then predict.
  task automatic send_slot(input req_t slot);
    in_req   = slot;
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_stall);
    expected_slots.push_back(advance_slot(slot));
    slots_sent++;
    @(negedge clk_i);
    // Drop valid for a random burst now and then.
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
  endtask

  // Feed slots until the running command ends. During an ack wait SDA stays
  // high for the first high_polls polls and then drops low.
  task automatic finish_command(input int high_polls, input bit noise);
    logic [12:0] bits;
    req_t        slot;
    int          polls;
    polls = 0;
    while (line_phase != PH_IDLE) begin
      bits = 13'($urandom);
      slot = bits;
      if (!noise) slot.op = OP_NONE;
      if (line_phase == PH_WA_POLL) begin
        slot.sda_in = (polls < high_polls);
        polls++;
      end
      send_slot(slot);
    end
  endtask

  task automatic run_command(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                             input int high_polls, input bit noise);
    req_t slot;
    slot.op       = op;
    slot.tx_byte  = tx;
    slot.send_ack = ack;
    slot.sda_in   = 1'($urandom_range(0, 1));
    send_slot(slot);
    finish_command(high_polls, noise);
  endtask

  // Hold off until every result is back.
  task automatic settle();
    int guard;
    in_valid = 1'b0;
    guard    = 0;
    while (expected_slots.size() != 0 && guard < 5000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_ack_timeout(input logic [7:0] value);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk_i); while (!cfg_ready);
    line_timeout = value;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s error, expected %0h actual %0h", $realtime, name, want, got);
      errors++;
    end
  endfunction

  // Compare every accepted result with the oldest prediction.
  task automatic check_result(input res_t got);
    res_t want;
    if (expected_slots.size() == 0) begin
      $display("%0t: unexpected result, expected none actual %0h", $realtime, got);
      errors++;
    end else begin
      want = expected_slots.pop_front();
      compare_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
      compare_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
      compare_field("ready_res", 8'(want.ready_res), 8'(got.ready_res));
      compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
      compare_field("rx_byte", want.rx_byte, got.rx_byte);
      compare_field("ack_failed", 8'(want.ack_failed), 8'(got.ack_failed));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) check_result(out_res);
  end

  // Stall the result channel in random bursts, except in the calm phase.
  always begin
    @(negedge clk_i);
    if (!calm && rst_ni && $urandom_range(0, 7) == 0) begin
      out_stall = 1'b1;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
      out_stall = 1'b0;
    end
  end

  // Idle slots: no command and the unused codes leave the lines as they are.
  task automatic test_idle_slots();
    run_command(OP_NONE, 8'h00, 1'b0, 0, 1'b0);
    run_command(OP_RSVD_A, 8'hFF, 1'b1, 0, 1'b0);
    run_command(OP_RSVD_B, 8'hA5, 1'b0, 0, 1'b0);
    run_command(OP_NONE, 8'hFF, 1'b1, 0, 1'b0);
  endtask

  // Start, both byte extremes, an immediate ack; some busy slots carry junk ops.
  task automatic test_write_bytes();
    run_command(OP_START, 8'h00, 1'b0, 0, 1'b0);
    run_command(OP_WRITE, 8'hFF, 1'b0, 0, 1'b1);
    run_command(OP_WRITE, 8'h00, 1'b1, 0, 1'b0);
    run_command(OP_WAIT, 8'h00, 1'b0, 0, 1'b1);
  endtask

  // Read with ACK, read with NACK, then release the bus.
  task automatic test_read_bytes();
    run_command(OP_READ, 8'h00, 1'b1, 0, 1'b0);
    run_command(OP_READ, 8'hFF, 1'b0, 0, 1'b1);
    run_command(OP_STOP, 8'h00, 1'b0, 0, 1'b0);
  endtask

  // Zero limit fails on the first high poll; a later success clears the flag.
  task automatic test_ack_timeout();
    settle();
    write_ack_timeout(8'd0);
    run_command(OP_WAIT, 8'h00, 1'b0, 5, 1'b0);
    run_command(OP_WAIT, 8'h00, 1'b0, 0, 1'b0);
    settle();
    write_ack_timeout(8'd4);
    run_command(OP_WAIT, 8'h00, 1'b0, 2, 1'b0);
    run_command(OP_WAIT, 8'h00, 1'b0, 9, 1'b0);
  endtask

  // Lower the limit in the middle of a wait: the next high poll fails.
  task automatic test_timeout_lowered();
    req_t slot;
    settle();
    write_ack_timeout(8'd10);
    slot = '0;
    slot.op = OP_WAIT;
    send_slot(slot);
    slot.op     = OP_NONE;
    slot.sda_in = 1'b1;
    repeat (4) send_slot(slot);
    settle();
    write_ack_timeout(8'd1);
    finish_command(100, 1'b0);
  endtask

  // Mostly well-formed commands with random content, some junk codes and
  // noise on busy slots.
  task automatic test_random_traffic(input logic [7:0] timeout, input int count,
                                     input bit calm_mode, input bit long_wait);
    int         target;
    int         high_polls;
    logic [2:0] op;
    settle();
    write_ack_timeout(timeout);
    calm   = calm_mode;
    target = slots_sent + count;
    // Run one wait out to the full limit.
    if (long_wait) run_command(OP_WAIT, 8'h00, 1'b0, 300, 1'b0);
    while (slots_sent < target) begin
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 2))
          0:       op = OP_NONE;
          1:       op = OP_RSVD_A;
          default: op = OP_RSVD_B;
        endcase
      end else begin
        op = 3'($urandom_range(OP_START, OP_READ));
      end
      if (timeout <= 8'd16) high_polls = $urandom_range(0, timeout + 2);
      else high_polls = $urandom_range(0, 12);
      run_command(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), high_polls,
                  $urandom_range(0, 9) < 3);
    end
  endtask

  initial begin
    int guard;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_req       = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    errors       = 0;
    slots_sent   = 0;
    calm         = 1'b0;
    // Predicted state after reset.
    line_phase   = PH_IDLE;
    line_sub     = '0;
    line_bit     = '0;
    line_shift   = '0;
    line_polls   = '0;
    line_timeout = ACK_TIMEOUT_RESET;
    line_rx      = '0;
    line_scl     = 1'b1;
    line_sda     = 1'b1;
    line_ack     = 1'b0;
    line_fail    = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_idle_slots();
    test_write_bytes();
    test_read_bytes();
    test_ack_timeout();
    test_timeout_lowered();
    test_random_traffic(8'd3, 300, 1'b0, 1'b0);
    test_random_traffic(8'd0, 200, 1'b0, 1'b0);
    test_random_traffic(8'd255, 250, 1'b0, 1'b1);
    test_random_traffic(8'($urandom_range(1, 15)), 300, 1'b1, 1'b0);

    // Drain, then wait for late results to show up.
    in_valid = 1'b0;
    guard    = 0;
    while (expected_slots.size() != 0 && guard < 5000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (8) @(negedge clk_i);
    if (expected_slots.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $realtime, expected_slots.size());
    end
    if (errors == 0 && expected_slots.size() == 0) begin
      $display("i2c_master_bit_sequencer_top: match");
    end else begin
      $display("i2c_master_bit_sequencer_top: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("i2c_master_bit_sequencer_top: mismatch");
    $finish;
  end

endmodule
